>>> design/dtb_pkg.sv
// Shared types, constants and helper functions of the dominator tree builder.
// Used by dtb_store, dtb_set_unit and dominator_tree_builder; depends on nothing.
package dtb_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W    = 4;
	localparam int ADDR_W    = $clog2(MAX_NODES);
	localparam int SET_W     = MAX_NODES;
	localparam int CNT_W     = $clog2(SET_W + 1);
	localparam int LIVE_MAX  = (MAX_NODES < 16) ? MAX_NODES : 16;

	localparam logic [1:0] MODE_ADD_ARC = 2'd0;
	localparam logic [1:0] MODE_COMPUTE = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	localparam logic CFG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]        mode;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] idom;
		logic              has_idom;
		logic              last;
	} rsp_t;

	// Control from the sequencer to the graph and dominator store.
	typedef struct packed {
		logic              row_set;
		logic              row_clear;
		logic [ADDR_W-1:0] row_src;
		logic [ADDR_W-1:0] row_dst;
		logic [ADDR_W-1:0] rd_addr;
		logic              dom_we;
		logic [ADDR_W-1:0] dom_waddr;
		logic [SET_W-1:0]  dom_wdata;
	} store_ctrl_t;

	// Results of the shared set unit.
	typedef struct packed {
		logic [SET_W-1:0] next_set;
		logic             changed;
		logic [CNT_W-1:0] count;
		logic             hit;
	} unit_res_t;

	function automatic logic [CNT_W-1:0] set_count(input logic [SET_W-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < SET_W; i++) begin
			c = c + CNT_W'(v[i]);
		end
		return c;
	endfunction

	function automatic logic [SET_W-1:0] live_mask(input logic [ADDR_W-1:0] last_node);
		logic [SET_W-1:0] m;
		m = '0;
		for (int i = 0; i < SET_W; i++) begin
			m[i] = (ADDR_W'(i) <= last_node);
		end
		return m;
	endfunction

endpackage

>>> design/dtb_store.sv
// Successor rows and dominator sets of the dominator tree builder, one read address.
// Depends on dtb_pkg.
module dtb_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dtb_pkg::store_ctrl_t        ctrl,
	output logic [dtb_pkg::SET_W-1:0]   row_rd,
	output logic [dtb_pkg::SET_W-1:0]   dom_rd
);
	import dtb_pkg::*;

	logic [SET_W-1:0] rows_q [MAX_NODES];
	logic [SET_W-1:0] dom_q  [MAX_NODES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) rows_q[i] <= '0;
		end else if (ctrl.row_clear) begin
			for (int i = 0; i < MAX_NODES; i++) rows_q[i] <= '0;
		end else if (ctrl.row_set) begin
			rows_q[ctrl.row_src][ctrl.row_dst] <= 1'b1;
		end
	end

	// Dominator sets are always rewritten by a compute before they are read.
	always_ff @(posedge clk) begin
		if (ctrl.dom_we) dom_q[ctrl.dom_waddr] <= ctrl.dom_wdata;
	end

	assign row_rd = rows_q[ctrl.rd_addr];
	assign dom_rd = dom_q[ctrl.rd_addr];

endmodule

>>> design/dtb_set_unit.sv
// Shared set unit: intersection with change detect, set size and candidate match.
// Depends on dtb_pkg.
module dtb_set_unit (
	input  logic [dtb_pkg::SET_W-1:0]  rd_set,
	input  logic [dtb_pkg::SET_W-1:0]  cur_set,
	input  logic [dtb_pkg::ADDR_W-1:0] sel,
	input  logic [dtb_pkg::CNT_W-1:0]  size,
	output dtb_pkg::unit_res_t         res
);
	import dtb_pkg::*;

	logic [SET_W-1:0] sel_bit;

	always_comb begin
		sel_bit      = '0;
		sel_bit[sel] = 1'b1;
		res.next_set = rd_set & (cur_set | sel_bit);
		res.changed  = (res.next_set != rd_set);
		res.count    = set_count(rd_set);
		res.hit      = cur_set[sel] &&
			(({1'b0, res.count} + (CNT_W+1)'(1)) == {1'b0, size});
	end

endmodule

>>> design/dominator_tree_builder.sv
// Top level of the dominator tree builder: configuration port, sequencer, result register.
// Depends on dtb_pkg, dtb_store and dtb_set_unit.
//
// Usage. Request words arrive on req (valid/ready). Mode 0 adds the arc src->dst, mode 2
// clears every arc. Mode 1 computes the dominator sets of nodes 0 to the highest live node
// (node_count-1, clamped to 0..LIVE_MAX-1) and then emits one response word per node 1 to
// the highest live node on rsp (valid/ready), each giving the immediate dominator and a
// found flag, with last set on the final word. Mode 3 is ignored.
// Steps of a compute: seed the sets of the live nodes, sweep them until a fixed point is
// reached, then per reported node a load step, a scan over the candidate nodes and a step
// to hand the word to the response register. Every step goes through the single read
// address of the dominator store and the shared set unit.
// req_ready is high only while the sequencer is idle, so arcs load one per cycle while no
// compute runs; a compute holds the request side until its last word has entered the
// response register. A stalled receiver holds it and the sequencer waits at its emit step.
// node_count is written via APB (register 0, reset value 16); the user must write it only
// while idle, which the block does not enforce. Reset clears all arcs, the response valid
// flag and the sequencer; dominator sets are not cleared, as every compute seeds them first.
module dominator_tree_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  dtb_pkg::req_t       req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dtb_pkg::rsp_t       rsp
);
	import dtb_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_INIT  = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_UPD   = 7'b0001000,
		ST_ELOAD = 7'b0010000,
		ST_SCAN  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} st_t;

	st_t               state_q;
	logic [4:0]        node_count_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] sub_q;
	logic              moved_q;
	logic [SET_W-1:0]  cur_q;
	logic [SET_W-1:0]  row_q;
	logic [CNT_W-1:0]  size_q;
	logic              found_q;
	logic [ADDR_W-1:0] pick_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [ADDR_W-1:0] last_node;
	logic [SET_W-1:0]  full_mask;
	store_ctrl_t       ctrl;
	logic [SET_W-1:0]  row_rd;
	logic [SET_W-1:0]  dom_rd;
	unit_res_t         ures;
	logic              req_acc;
	logic              upd_write;
	logic              emit_go;

	// Configuration: register 0 sits at byte address 0; low address bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_NODE_COUNT) ? 32'(node_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 5'd16;
		end else if (psel && penable && pwrite && pready && paddr[2] == CFG_NODE_COUNT) begin
			node_count_q <= pwdata[4:0];
		end
	end

	// Highest live node: the count is clamped to at least one and at most LIVE_MAX.
	always_comb begin
		if (node_count_q == 5'd0) begin
			last_node = '0;
		end else if (32'(node_count_q) > LIVE_MAX) begin
			last_node = ADDR_W'(LIVE_MAX - 1);
		end else begin
			last_node = ADDR_W'(node_count_q - 5'd1);
		end
	end

	assign full_mask = live_mask(last_node);
	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign upd_write = (state_q == ST_UPD) && row_q[sub_q] && ures.changed;
	assign emit_go   = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);

	// Store control: one read address, chosen by the step in progress.
	always_comb begin
		ctrl.row_set   = req_acc && req.mode == MODE_ADD_ARC &&
			{1'b0, req.src_node} < (NODE_W+1)'(MAX_NODES) &&
			{1'b0, req.dst_node} < (NODE_W+1)'(MAX_NODES);
		ctrl.row_clear = req_acc && req.mode == MODE_CLEAR;
		ctrl.row_src   = ADDR_W'(req.src_node);
		ctrl.row_dst   = ADDR_W'(req.dst_node);
		ctrl.rd_addr   = ((state_q == ST_UPD) || (state_q == ST_SCAN)) ? sub_q : idx_q;
		ctrl.dom_we    = (state_q == ST_INIT) || upd_write;
		ctrl.dom_waddr = (state_q == ST_INIT) ? idx_q : sub_q;
		if (state_q == ST_INIT) begin
			ctrl.dom_wdata = (idx_q == '0) ? SET_W'(1) : full_mask;
		end else begin
			ctrl.dom_wdata = ures.next_set;
		end
	end

	dtb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.row_rd (row_rd),
		.dom_rd (dom_rd)
	);

	dtb_set_unit u_unit (
		.rd_set  (dom_rd),
		.cur_set (cur_q),
		.sel     (sub_q),
		.size    (size_q),
		.res     (ures)
	);

	// Sequencer. The cached set of the swept node stays exact through its own
	// successor loop, since a self arc never removes anything from that set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			sub_q   <= '0;
			moved_q <= 1'b0;
			found_q <= 1'b0;
			pick_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && req.mode == MODE_COMPUTE) begin
						idx_q   <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (idx_q == last_node) begin
						idx_q   <= '0;
						moved_q <= 1'b0;
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LOAD: begin
					sub_q   <= '0;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_write) moved_q <= 1'b1;
					if (sub_q == last_node) begin
						if (idx_q != last_node) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_LOAD;
						end else if (moved_q || upd_write) begin
							idx_q   <= '0;
							moved_q <= 1'b0;
							state_q <= ST_LOAD;
						end else if (last_node == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= ADDR_W'(1);
							state_q <= ST_ELOAD;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_ELOAD: begin
					sub_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (ures.hit) begin
						found_q <= 1'b1;
						pick_q  <= sub_q;
						state_q <= ST_EMIT;
					end else if (sub_q == last_node) begin
						found_q <= 1'b0;
						pick_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (idx_q == last_node) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_ELOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working copies of the node under sweep or under report.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			cur_q <= dom_rd;
			row_q <= row_rd & full_mask;
		end else if (state_q == ST_ELOAD) begin
			cur_q  <= dom_rd;
			size_q <= ures.count;
		end
	end

	// Response register: decouples the sequencer from a stalling receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp_q.node     <= NODE_W'(idx_q);
			rsp_q.idom     <= NODE_W'(pick_q);
			rsp_q.has_idom <= found_q;
			rsp_q.last     <= (idx_q == last_node);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The root is never reported.
	a_no_root: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.node != '0)
		else $error("root node reported");

	// A missing immediate dominator is reported as zero.
	a_idom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.has_idom) |-> rsp_q.idom == '0)
		else $error("idom not zero without a dominator");

	// A compute word always starts the seeding pass.
	a_compute_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.mode == MODE_COMPUTE) |=> state_q == ST_INIT)
		else $error("compute did not start seeding");

	// A sweep update only ever removes members from a set.
	a_shrink_only: assert property (@(posedge clk) disable iff (!arst_n)
		upd_write |-> (ures.next_set & ~dom_rd) == '0)
		else $error("dominator set grew");

endmodule
